@@ src/distance_vector_route_table_defines.svh @@
// ----------------------------------------------------------------------------
// distance_vector_route_table_defines
// assertion macros used by the route table checker
// ----------------------------------------------------------------------------
`ifndef DISTANCE_VECTOR_ROUTE_TABLE_DEFINES_SVH
`define DISTANCE_VECTOR_ROUTE_TABLE_DEFINES_SVH

// property checked while out of reset
`define DVRT_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property that also covers the reset cycles
`define DVRT_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ src/dvrt_pkg.sv @@
// ----------------------------------------------------------------------------
// dvrt_pkg
// types and constants of the distance-vector route table
// ----------------------------------------------------------------------------
package dvrt_pkg;

   localparam int ADDR_W = 4;
   localparam int COST_W = 5;
   localparam int LIFE_W = 4;
   localparam int DEPTH  = 16;

   localparam logic [ADDR_W-1:0] MAX_NODES      = 4'd15;
   localparam logic [COST_W-1:0] INFINITE_COST  = 5'd16;
   localparam logic [COST_W-1:0] MAX_PATH_COST  = 5'd15;
   localparam logic [LIFE_W-1:0] ROUTE_LIFETIME = 4'd15;

   typedef enum logic {
      ACT_UPDATE    = 1'b0,
      ACT_ADVERTISE = 1'b1
   } action_type;

   typedef enum logic {
      CSR_OWN_ADDRESS = 1'b0,
      CSR_LINK_COST   = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic              action;
      logic [ADDR_W-1:0] neighbor_addr;
      logic [ADDR_W-1:0] dest_addr;
      logic [COST_W-1:0] adv_cost;
   } req_type;

   typedef struct packed {
      logic [COST_W-1:0] out_cost;
      logic [ADDR_W-1:0] out_next_hop;
      logic              entry_valid;
      logic              changed;
   } rsp_type;

   typedef struct packed {
      logic              valid;
      logic [COST_W-1:0] cost;
      logic [ADDR_W-1:0] hop;
      logic [LIFE_W-1:0] lifetime;
   } entry_type;

endpackage

@@ src/dvrt_route_logic.sv @@
// ----------------------------------------------------------------------------
// dvrt_route_logic
// next value of one route entry and the result for one request
// ----------------------------------------------------------------------------
module dvrt_route_logic
   import dvrt_pkg::*;
(
   input  req_type           item,
   input  entry_type         entry,
   input  logic [ADDR_W-1:0] own_address,
   input  logic [ADDR_W-1:0] link_weight,
   output logic              entry_we,
   output entry_type         entry_new,
   output rsp_type           rsp
);

   logic              is_own;
   logic              in_range;
   logic [COST_W:0]   sum;
   logic              unreachable;
   logic              via_neighbor;
   logic              take;
   logic              poison;
   logic              chg;

   always_comb begin
      is_own       = (item.dest_addr == own_address);
      in_range     = (item.dest_addr != '0) && (item.dest_addr <= MAX_NODES);
      sum          = {1'b0, item.adv_cost} + {{(COST_W+1-ADDR_W){1'b0}}, link_weight};
      unreachable  = (item.adv_cost >= INFINITE_COST);
      via_neighbor = entry.valid && (entry.hop == item.neighbor_addr);
      take         = !unreachable && (sum <= {1'b0, MAX_PATH_COST})
                     && (!entry.valid || ({1'b0, entry.cost} > sum)
                         || (entry.cost == INFINITE_COST) || (entry.lifetime == '0));
      poison       = unreachable && via_neighbor;

      entry_we  = 1'b0;
      entry_new = entry;
      chg       = 1'b0;
      rsp       = '{out_cost: INFINITE_COST, out_next_hop: '0, entry_valid: 1'b0,
                    changed: 1'b0};

      if (is_own) begin
         rsp = '{out_cost: '0, out_next_hop: own_address, entry_valid: 1'b1,
                 changed: 1'b0};
      end else if (in_range) begin
         if (item.action == ACT_UPDATE) begin
            if (poison) begin
               entry_new.cost = INFINITE_COST;
               entry_we       = 1'b1;
               chg            = 1'b1;
            end else if (take) begin
               entry_new = '{valid: 1'b1, cost: sum[COST_W-1:0],
                             hop: item.neighbor_addr, lifetime: ROUTE_LIFETIME};
               entry_we  = 1'b1;
               chg       = 1'b1;
            end
            if (entry_new.valid) begin
               rsp = '{out_cost: entry_new.cost, out_next_hop: entry_new.hop,
                       entry_valid: 1'b1, changed: chg};
            end else begin
               rsp.changed = chg;
            end
         end else if (entry.valid) begin
            // split horizon with poison reverse, then age the entry
            if (entry.lifetime != '0) begin
               entry_new.lifetime = entry.lifetime - 1'b1;
               entry_we           = 1'b1;
            end
            rsp = '{out_cost: via_neighbor ? INFINITE_COST : entry.cost,
                    out_next_hop: entry.hop, entry_valid: 1'b1, changed: 1'b0};
         end
      end
   end

endmodule

@@ src/distance_vector_route_table.sv @@
// a request accepted into the request register shows its response from the response
// register; throughput: one request per cycle unless the response is stalled; the
// entry read and update are combinational, written back as the response is registered
// reset: synchronous, active high; all route entries become absent, own_address
// and the link weight return to 1, both pipeline registers empty
// ----------------------------------------------------------------------------
// distance_vector_route_table
// distance-vector route table with split horizon and poison reverse
// ----------------------------------------------------------------------------
module distance_vector_route_table
   import dvrt_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  req_type           req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data,
   input  logic              csr_we,
   input  logic              csr_index,
   input  logic [ADDR_W-1:0] csr_wdata
);

   logic [ADDR_W-1:0] own_address_ff, own_address_in;
   logic [ADDR_W-1:0] link_weight_ff, link_weight_in;

   logic              s1_valid_ff, s1_valid_in;
   req_type           s1_item_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff;

   logic [DEPTH-1:0]  valid_ff;
   logic [COST_W-1:0] cost_ff [DEPTH];
   logic [ADDR_W-1:0] hop_ff  [DEPTH];
   logic [LIFE_W-1:0] life_ff [DEPTH];

   logic              advance;
   logic              entry_we;
   entry_type         entry_cur;
   entry_type         entry_new;
   rsp_type           rsp_new;
   logic [ADDR_W-1:0] idx;

   assign idx       = s1_item_ff.dest_addr;
   assign entry_cur = '{valid: valid_ff[idx], cost: cost_ff[idx], hop: hop_ff[idx],
                        lifetime: life_ff[idx]};

   dvrt_route_logic u_logic (
      .item        (s1_item_ff),
      .entry       (entry_cur),
      .own_address (own_address_ff),
      .link_weight (link_weight_ff),
      .entry_we    (entry_we),
      .entry_new   (entry_new),
      .rsp         (rsp_new)
   );

   assign advance   = s1_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !s1_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      own_address_in = own_address_ff;
      link_weight_in = link_weight_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_OWN_ADDRESS: own_address_in = csr_wdata;
            CSR_LINK_COST:   link_weight_in = csr_wdata;
            default: ;
         endcase
      end
      s1_valid_in  = (req_valid && req_ready) || (s1_valid_ff && !advance);
      rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_address_ff <= 4'd1;
         link_weight_ff <= 4'd1;
         s1_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         valid_ff       <= '0;
      end else begin
         own_address_ff <= own_address_in;
         link_weight_ff <= link_weight_in;
         s1_valid_ff    <= s1_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (advance && entry_we) begin
            valid_ff[idx] <= entry_new.valid;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_item_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_new;
      end
      if (advance && entry_we) begin
         cost_ff[idx] <= entry_new.cost;
         hop_ff[idx]  <= entry_new.hop;
         life_ff[idx] <= entry_new.lifetime;
      end
   end

endmodule

@@ src/dvrt_checker.sv @@
// ----------------------------------------------------------------------------
// dvrt_checker
// port-level checks of the route table response channel
// ----------------------------------------------------------------------------
`include "distance_vector_route_table_defines.svh"

module dvrt_checker
   import dvrt_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input rsp_type rsp_data
);

   // a stalled beat keeps its payload
   `DVRT_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data), "response dropped or changed while stalled")

   `DVRT_ASSERT_RST(a_rsp_reset, reset |=> !rsp_valid, "response valid right after reset")

   // an absent route always reads as unreachable with no next hop
   `DVRT_ASSERT(a_absent_route, rsp_valid && !rsp_data.entry_valid |-> rsp_data.out_cost == INFINITE_COST && rsp_data.out_next_hop == '0, "absent route not reported as unreachable")

   // a rewrite or poison leaves a live entry behind
   `DVRT_ASSERT(a_changed_valid, rsp_valid && rsp_data.changed |-> rsp_data.entry_valid, "changed entry reported as absent")

endmodule

bind distance_vector_route_table dvrt_checker u_dvrt_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
